/* rtl/cmn_pkg.sv */
// Shared types and constants for the cepstral mean normalizer.
// No dependencies; imported by every module of the block.
package cmn_pkg;

    localparam int VAL_W = 32;       // coefficient width
    localparam int CFG_W = 5;        // coefs_per_frame register width
    localparam int STAT_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd13;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_EMIT = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTHING = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT     = 2'd3;

    // divider control from the sequencer
    typedef struct packed {
        logic start;
        logic negate;
    } div_ctl_t;

endpackage

/* rtl/cmn_sample_ram.sv */
// Single-port sample store with registered read data.
// Depends on cmn_pkg for the coefficient width.
module cmn_sample_ram #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             addr,
    input  logic [cmn_pkg::VAL_W-1:0] wdata,
    output logic [cmn_pkg::VAL_W-1:0] rdata
);
    import cmn_pkg::*;

    logic [VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/cmn_divider.sv */
// Shared restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on cmn_pkg for the control struct.
module cmn_divider #(
    parameter int DD_W = 42,
    parameter int DV_W = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmn_pkg::div_ctl_t ctl,
    input  logic [DD_W-1:0]   dividend,   // magnitude
    input  logic [DV_W-1:0]   divisor,    // nonzero
    output logic              done,
    output logic [DD_W-1:0]   quotient
);
    import cmn_pkg::*;

    localparam int CNT_W = $clog2(DD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DD_W-1:0]  quo_reg;
    logic [DV_W-1:0]  rem_reg;
    logic [DV_W-1:0]  dvs_reg;

    logic [DV_W:0]    trial;
    logic [DV_W:0]    diff;
    logic             fits;
    logic [DV_W-1:0]  rem_next;

    assign trial    = {rem_reg, quo_reg[DD_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign rem_next = fits ? diff[DV_W-1:0] : trial[DV_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            neg_reg <= ctl.negate;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + DD_W'(1)) : quo_reg;

endmodule

/* rtl/cepstral_mean_normalizer_unit.sv */
// Cepstral mean normalizer: top level with the batch sequencer.
// Depends on cmn_pkg, cmn_sample_ram and cmn_divider.
//
// Usage:
//   in channel  (in_valid/in_ready, action, coef_value): one request per item.
//     action LOAD appends coef_value to the store (status FULL if it is full or
//     emitting); EMIT returns the next stored coefficient minus its column mean.
//   out channel (out_valid/out_ready, norm_value, last_out, status): exactly
//     one result per request, in request order, held in an output register.
//   cfg channel (cfg_valid/cfg_ready, cfg_data): coefs_per_frame, always ready.
// Sequence (accept to result in the output register):
//   load: S_RESP; emit while emitting: S_EMIT_RD, S_EMIT_CALC, S_RESP;
//   in_ready returns with the result.
//   first emit of a batch: the frame count division, then a sum sweep
//   (S_SUM_RD, S_SUM_ACC per stored coefficient) through the single RAM port,
//   then one shared-divider pass per column, then the emit.
//   DD_W = 33 + clog2(MAX_FRAMES), 42 at the default.
// One request is in flight at a time; in_ready is high only when the
// sequencer is idle. A finished result waits in its own stage while the
// output register is full, so a stalled receiver holds off the next request.
// Reset: coefs_per_frame = 13, store empty, loading phase; no clearing pass.
// After the last emit of a batch the block returns to the loading phase.
module cepstral_mean_normalizer_unit #(
    parameter int MAX_FRAMES = 512,
    parameter int MAX_COEFS  = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       action,
    input  logic [cmn_pkg::VAL_W-1:0]  coef_value,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cmn_pkg::VAL_W-1:0]  norm_value,
    output logic                       last_out,
    output logic [cmn_pkg::STAT_W-1:0] status,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [cmn_pkg::CFG_W-1:0]  cfg_data
);
    import cmn_pkg::*;

    localparam int DEPTH = MAX_FRAMES * MAX_COEFS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LC_W  = $clog2(DEPTH + 1);          // load count / pointer
    localparam int FR_W  = $clog2(MAX_FRAMES + 1);     // frame count
    localparam int W_W   = $clog2(MAX_COEFS + 1);      // frame width
    localparam int CW    = (MAX_COEFS > 1) ? $clog2(MAX_COEFS) : 1;
    localparam int SUM_W = VAL_W + 1 + $clog2(MAX_FRAMES);
    localparam int DD_W  = SUM_W;
    localparam int DV_W  = (FR_W > W_W) ? FR_W : W_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_FRAMES,
        S_SUM_RD,
        S_SUM_ACC,
        S_MEAN_START,
        S_MEAN_WAIT,
        S_EMIT_RD,
        S_EMIT_CALC,
        S_RESP
    } state_t;

    // sequencer state
    state_t            state_reg,     state_next;
    logic [CFG_W-1:0]  cfg_reg;
    logic [LC_W-1:0]   load_cnt_reg,  load_cnt_next;
    logic              emitting_reg,  emitting_next;
    logic [LC_W-1:0]   ptr_reg,       ptr_next;
    logic [CW-1:0]     col_reg,       col_next;
    logic [W_W-1:0]    lw_reg,        lw_next;
    logic [FR_W-1:0]   frames_reg,    frames_next;
    logic [LC_W-1:0]   total_reg,     total_next;
    logic              first_reg,     first_next;
    // pending result
    logic [VAL_W-1:0]  res_norm_reg,  res_norm_next;
    logic              res_last_reg,  res_last_next;
    logic [STAT_W-1:0] res_stat_reg,  res_stat_next;
    // output register
    logic              out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]  out_norm_reg,  out_norm_next;
    logic              out_last_reg,  out_last_next;
    logic [STAT_W-1:0] out_stat_reg,  out_stat_next;

    // per-column storage
    logic [SUM_W-1:0]  sums  [MAX_COEFS];
    logic [VAL_W-1:0]  means [MAX_COEFS];

    logic              accept;
    logic [W_W-1:0]    eff_w;
    logic [LC_W-1:0]   load_limit;
    logic              load_ok;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [VAL_W-1:0]  ram_rdata;
    div_ctl_t          div_ctl;
    logic [DD_W-1:0]   div_dividend;
    logic [DV_W-1:0]   div_divisor;
    logic              div_done;
    logic [DD_W-1:0]   div_quot;
    logic [SUM_W-1:0]  sum_cur;
    logic [SUM_W-1:0]  sum_mag;
    logic              sum_wr;
    logic [SUM_W-1:0]  sum_wdata;
    logic              mean_wr;
    logic [W_W-1:0]    col_inc;
    logic              col_wrap;
    logic [LC_W:0]     ptr_inc;
    logic [FR_W-1:0]   frames_cap;
    logic [VAL_W:0]    diff;
    logic              out_free;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    // register value clamped to 1..MAX_COEFS
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            eff_w = W_W'(1);
        end
        else if (32'(cfg_reg) > MAX_COEFS)
        begin
            eff_w = W_W'(MAX_COEFS);
        end
        else
        begin
            eff_w = W_W'(cfg_reg);
        end
    end

    assign load_limit = LC_W'(MAX_FRAMES) * LC_W'(eff_w);
    assign load_ok    = !emitting_reg && (load_cnt_reg < load_limit) &&
                        (load_cnt_reg < LC_W'(DEPTH));
    assign ram_we     = accept && (action == ACT_LOAD) && load_ok;
    assign ram_addr   = ram_we ? load_cnt_reg[AW-1:0] : ptr_reg[AW-1:0];

    assign col_inc  = W_W'(col_reg) + W_W'(1);
    assign col_wrap = (col_inc == lw_reg);
    assign ptr_inc  = {1'b0, ptr_reg} + (LC_W+1)'(1);

    assign sum_cur = sums[col_reg];
    assign sum_mag = sum_cur[SUM_W-1] ? (~sum_cur + SUM_W'(1)) : sum_cur;

    // one divider: frame count at batch close, then each column mean
    always_comb
    begin
        div_ctl.start  = 1'b0;
        div_ctl.negate = 1'b0;
        div_dividend   = DD_W'(load_cnt_reg);
        div_divisor    = DV_W'(eff_w);
        if (state_reg == S_MEAN_START)
        begin
            div_ctl.start  = 1'b1;
            div_ctl.negate = sum_cur[SUM_W-1];
            div_dividend   = sum_mag;
            div_divisor    = DV_W'(frames_reg);
        end
        else if (accept && (action == ACT_EMIT) && !emitting_reg)
        begin
            div_ctl.start = 1'b1;
        end
    end

    assign frames_cap = (div_quot > DD_W'(MAX_FRAMES)) ? FR_W'(MAX_FRAMES)
                                                       : div_quot[FR_W-1:0];

    assign sum_wr    = (state_reg == S_SUM_ACC);
    assign sum_wdata = (first_reg ? SUM_W'(0) : sum_cur) +
                       {{(SUM_W-VAL_W){ram_rdata[VAL_W-1]}}, ram_rdata};
    assign mean_wr   = (state_reg == S_MEAN_WAIT) && div_done;

    assign diff = {ram_rdata[VAL_W-1], ram_rdata} -
                  {means[col_reg][VAL_W-1], means[col_reg]};

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        emitting_next  = emitting_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        lw_next        = lw_reg;
        frames_next    = frames_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        res_norm_next  = res_norm_reg;
        res_last_next  = res_last_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_norm_next  = out_norm_reg;
        out_last_next  = out_last_reg;
        out_stat_next  = out_stat_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_norm_next = '0;
                    res_last_next = 1'b0;
                    res_stat_next = ST_OK;
                    if (action == ACT_LOAD)
                    begin
                        state_next = S_RESP;
                        if (load_ok)
                        begin
                            load_cnt_next = load_cnt_reg + LC_W'(1);
                        end
                        else
                        begin
                            res_stat_next = ST_FULL;
                        end
                    end
                    else if (emitting_reg)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        state_next = S_DIV_FRAMES;
                    end
                end
            end
            S_DIV_FRAMES:
            begin
                if (div_done)
                begin
                    if (frames_cap == '0)
                    begin
                        res_stat_next = ST_NOTHING;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        frames_next = frames_cap;
                        lw_next     = eff_w;
                        total_next  = LC_W'(frames_cap) * LC_W'(eff_w);
                        ptr_next    = '0;
                        col_next    = '0;
                        first_next  = 1'b1;
                        state_next  = S_SUM_RD;
                    end
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                ptr_next = ptr_inc[LC_W-1:0];
                if (col_wrap)
                begin
                    col_next   = '0;
                    first_next = 1'b0;
                end
                else
                begin
                    col_next = CW'(col_inc);
                end
                if (ptr_inc == {1'b0, total_reg})
                begin
                    ptr_next   = '0;
                    col_next   = '0;
                    state_next = S_MEAN_START;
                end
                else
                begin
                    state_next = S_SUM_RD;
                end
            end
            S_MEAN_START:
            begin
                state_next = S_MEAN_WAIT;
            end
            S_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    if (col_wrap)
                    begin
                        col_next      = '0;
                        ptr_next      = '0;
                        emitting_next = 1'b1;
                        state_next    = S_EMIT_RD;
                    end
                    else
                    begin
                        col_next   = CW'(col_inc);
                        state_next = S_MEAN_START;
                    end
                end
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_CALC;
            end
            S_EMIT_CALC:
            begin
                // clamp the 33-bit difference to the 32-bit range
                if (!diff[VAL_W] && diff[VAL_W-1])
                begin
                    res_norm_next = {1'b0, {(VAL_W-1){1'b1}}};
                    res_stat_next = ST_SAT;
                end
                else if (diff[VAL_W] && !diff[VAL_W-1])
                begin
                    res_norm_next = {1'b1, {(VAL_W-1){1'b0}}};
                    res_stat_next = ST_SAT;
                end
                else
                begin
                    res_norm_next = diff[VAL_W-1:0];
                end
                ptr_next = ptr_inc[LC_W-1:0];
                col_next = col_wrap ? '0 : CW'(col_inc);
                if (ptr_inc >= {1'b0, total_reg})
                begin
                    // end of batch: back to loading
                    res_last_next = 1'b1;
                    load_cnt_next = '0;
                    emitting_next = 1'b0;
                    ptr_next      = '0;
                    col_next      = '0;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_norm_next  = res_norm_reg;
                    out_last_next  = res_last_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cfg_reg       <= CFG_RESET;
            load_cnt_reg  <= '0;
            emitting_reg  <= 1'b0;
            ptr_reg       <= '0;
            col_reg       <= '0;
            lw_reg        <= '0;
            frames_reg    <= '0;
            total_reg     <= '0;
            first_reg     <= 1'b0;
            res_norm_reg  <= '0;
            res_last_reg  <= 1'b0;
            res_stat_reg  <= ST_OK;
            out_valid_reg <= 1'b0;
            out_norm_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_stat_reg  <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            load_cnt_reg  <= load_cnt_next;
            emitting_reg  <= emitting_next;
            ptr_reg       <= ptr_next;
            col_reg       <= col_next;
            lw_reg        <= lw_next;
            frames_reg    <= frames_next;
            total_reg     <= total_next;
            first_reg     <= first_next;
            res_norm_reg  <= res_norm_next;
            res_last_reg  <= res_last_next;
            res_stat_reg  <= res_stat_next;
            out_valid_reg <= out_valid_next;
            out_norm_reg  <= out_norm_next;
            out_last_reg  <= out_last_next;
            out_stat_reg  <= out_stat_next;
        end
    end

    // column sums and means
    always_ff @(posedge clk)
    begin
        if (sum_wr)
        begin
            sums[col_reg] <= sum_wdata;
        end
        if (mean_wr)
        begin
            means[col_reg] <= div_quot[VAL_W-1:0];
        end
    end

    cmn_sample_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (coef_value),
        .rdata (ram_rdata)
    );

    cmn_divider #(
        .DD_W (DD_W),
        .DV_W (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid  = out_valid_reg;
    assign norm_value = out_norm_reg;
    assign last_out   = out_last_reg;
    assign status     = out_stat_reg;

endmodule
